@@ design/sync_length_packet_deframer_assert.svh @@
// Assertion macros shared by sld_parse and sld_out_stage.
// Depends on nothing; each user must have aclk and aresetn in scope.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sld_pkg.sv @@
// Shared types and constants of the sync/length packet deframer.
// Depends on nothing.
package sld_pkg;

    // Sync pattern that opens every packet.
    localparam logic [7:0] SYNC_FIRST  = 8'h5A;
    localparam logic [7:0] SYNC_SECOND = 8'hA5;

    // Result kinds.
    localparam logic [1:0] KIND_BODY     = 2'd0;
    localparam logic [1:0] KIND_MISMATCH = 2'd1;
    localparam logic [1:0] KIND_ZERO_LEN = 2'd2;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

@@ design/sync_length_packet_deframer.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// input    | s_valid / s_ready    | s_byte_in[7:0]
// result   | m_valid / m_ready    | m_kind[1:0], m_data[7:0], m_last
// config   | cfg_valid / cfg_ready| cfg_data (1 = length big-endian)
//
// One byte is accepted per cycle while s_ready is high; each byte is held in the input register,
// passes through the parser, and its result, if any, is offered from the output register.
// Matching sync bytes and nonzero length bytes consume an item without giving a result.
// Synchronous active-low reset returns the parser to sync hunting, little-endian.
// A stalled result channel fills the output and skid entries; the next item then waits
// in the input register and s_ready stays low until the skid entry drains.
// Depends on sld_pkg, sld_in_stage, sld_parse and sld_out_stage.
module sync_length_packet_deframer
    import sld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic       big_endian_reg;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_take;
    logic       out_ready;
    logic       res_valid;
    result_t    res;

    // Byte order register, written through its own channel.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            big_endian_reg <= cfg_data;
        end
    end

    // Input register.
    sld_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .take_i    (in_take),
        .valid_o   (in_valid),
        .byte_o    (in_byte)
    );

    // Parser state machine.
    sld_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .big_endian_i (big_endian_reg),
        .in_valid_i   (in_valid),
        .in_byte_i    (in_byte),
        .in_take_o    (in_take),
        .out_ready_i  (out_ready),
        .res_valid_o  (res_valid),
        .res_o        (res)
    );

    // Result register with skid entry.
    sld_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (res_valid),
        .res_i   (res),
        .ready_o (out_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_data  (m_data),
        .m_last  (m_last)
    );

endmodule

@@ design/sld_in_stage.sv @@
// Input register of the deframer: holds one received byte for the parser.
// Depends on nothing outside this file.
module sld_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       take_i,
    output logic       valid_o,
    output logic [7:0] byte_o
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // A new item may enter when the register is empty or is being drained.
    assign s_ready    = !valid_reg || take_i;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take_i ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    assign valid_o = valid_reg;
    assign byte_o  = byte_reg;

endmodule

@@ design/sld_parse.sv @@
// Deframing state machine: sync hunt, length assembly and body forwarding.
// Depends on sld_pkg and the assertion macro header.
`include "sync_length_packet_deframer_assert.svh"

module sld_parse
    import sld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       big_endian_i,
    input  logic       in_valid_i,
    input  logic [7:0] in_byte_i,
    output logic       in_take_o,
    input  logic       out_ready_i,
    output logic       res_valid_o,
    output result_t    res_o
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_SYNC2  = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] accum_upd;
    logic [31:0] remain_dec;
    logic        has_res;
    result_t     res;

    // An item is consumed whenever the output side has room for a result.
    assign in_take_o = in_valid_i && out_ready_i;

    // Length byte placed by the byte order in force when it arrives.
    always_comb begin
        if (big_endian_i) begin
            accum_upd = {accum_reg[23:0], in_byte_i};
        end else begin
            case (count_reg)
                2'd0:    accum_upd = accum_reg | {24'd0, in_byte_i};
                2'd1:    accum_upd = accum_reg | {16'd0, in_byte_i, 8'd0};
                2'd2:    accum_upd = accum_reg | {8'd0, in_byte_i, 16'd0};
                default: accum_upd = accum_reg | {in_byte_i, 24'd0};
            endcase
        end
    end

    assign remain_dec = remain_reg - 32'd1;

    // Next state and result for the item held in the input register.
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        has_res     = 1'b0;
        res.kind    = KIND_BODY;
        res.data    = 8'd0;
        res.last    = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                if (in_byte_i == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                end else begin
                    has_res  = 1'b1;
                    res.kind = KIND_MISMATCH;
                end
            end
            PH_SYNC2: begin
                if (in_byte_i == SYNC_SECOND) begin
                    phase_next = PH_LENGTH;
                    count_next = 2'd0;
                    accum_next = 32'd0;
                end else begin
                    phase_next = PH_HUNT;
                    has_res    = 1'b1;
                    res.kind   = KIND_MISMATCH;
                end
            end
            PH_LENGTH: begin
                accum_next = accum_upd;
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd3) begin
                    if (accum_upd == 32'd0) begin
                        phase_next = PH_HUNT;
                        has_res    = 1'b1;
                        res.kind   = KIND_ZERO_LEN;
                    end else begin
                        remain_next = accum_upd;
                        accum_next  = 32'd0;
                        phase_next  = PH_BODY;
                    end
                end
            end
            default: begin
                remain_next = remain_dec;
                has_res     = 1'b1;
                res.kind    = KIND_BODY;
                res.data    = in_byte_i;
                if (remain_dec == 32'd0) begin
                    phase_next = PH_HUNT;
                    res.last   = 1'b1;
                end
            end
        endcase
    end

    // State moves only when an item is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            count_reg  <= 2'd0;
            accum_reg  <= 32'd0;
            remain_reg <= 32'd0;
        end else if (in_take_o) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
        end
    end

    assign res_valid_o = in_take_o && has_res;
    assign res_o       = res;

    // A packet body always has bytes still to come.
    `SLD_ASSERT_NOW(a_body_nonzero, phase_reg == PH_BODY, remain_reg != 32'd0, "body with zero count")
    // The final body byte returns the parser to hunting.
    `SLD_ASSERT_NEXT(a_last_to_hunt, res_valid_o && res_o.last, phase_reg == PH_HUNT, "no hunt after last")
    // Only body results carry data or a last marker.
    `SLD_ASSERT_NOW(a_status_clean, res_valid_o && res_o.kind != KIND_BODY, res_o.data == 8'd0 && !res_o.last, "status result carries data")

endmodule

@@ design/sld_out_stage.sv @@
// Output register with a skid entry, so results never stall the parser early.
// Depends on sld_pkg and the assertion macro header.
`include "sync_length_packet_deframer_assert.svh"

module sld_out_stage
    import sld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_i,
    input  result_t    res_i,
    output logic       ready_o,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data,
    output logic       m_last
);

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg;
    result_t skid_reg;
    logic    take;

    assign take    = main_v_reg && m_ready;
    assign ready_o = !skid_v_reg;

    // Occupancy of the two entries.
    always_comb begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        if (skid_v_reg) begin
            if (take) begin
                skid_v_next = 1'b0;
            end
        end else if (push_i) begin
            if (main_v_reg && !take) begin
                skid_v_next = 1'b1;
            end else begin
                main_v_next = 1'b1;
            end
        end else if (take) begin
            main_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // Payload moves: skid drains into main, or a new item lands.
    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (take) begin
                main_reg <= skid_reg;
            end
        end else if (push_i) begin
            if (main_v_reg && !take) begin
                skid_reg <= res_i;
            end else begin
                main_reg <= res_i;
            end
        end
    end

    assign m_valid = main_v_reg;
    assign m_kind  = main_reg.kind;
    assign m_data  = main_reg.data;
    assign m_last  = main_reg.last;

    // The skid entry is only used behind a held main entry.
    `SLD_ASSERT_NOW(a_skid_behind_main, skid_v_reg, main_v_reg, "skid entry without main entry")
    // Results arrive only when there is room.
    `SLD_ASSERT_NOW(a_push_room, push_i, ready_o, "result pushed while full")
    // A taken main entry is refilled from the skid entry.
    `SLD_ASSERT_NEXT(a_skid_drain, skid_v_reg && take, main_v_reg && !skid_v_reg, "skid not drained")

endmodule
